// File: rtl/core/cst_pkg.sv
// cst_pkg: constants, request and response types, codes and the sequencer
// state type for the cookie slot tracker
// no dependencies
package cst_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_BITS = 3;
  localparam int unsigned IdxW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CookieW   = 16;

  typedef enum logic [2:0] {
    REQ_ALLOC     = 3'd0,
    REQ_MARK_DONE = 3'd1,
    REQ_RELEASE   = 3'd2,
    REQ_CONSUME   = 3'd3,
    REQ_MARK_ALL  = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CHECK,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [CookieW-1:0] cookie_in;
    logic [CookieW-1:0] random_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CookieW-1:0] cookie_out;
    logic               done_flag;
  } rsp_t;

  // one access to the slot store per cycle
  typedef struct packed {
    logic [IdxW-1:0]    addr;
    logic               rd;
    logic               cookie_we;
    logic [CookieW-1:0] wdata;
    logic               set_occ;
    logic               clr_occ;
    logic               set_done;
    logic               clr_done;
  } store_cmd_t;

  function automatic logic slot_in_range(logic [SLOT_BITS-1:0] idx);
    return (32'(idx) < SLOTS);
  endfunction

endpackage

// File: rtl/core/cookie_slot_tracker.sv
// cookie_slot_tracker: top level of the handle table with generation cookies
// depends on cst_pkg, cst_slot_store and cst_ctrl
//
// A table of SLOTS handles, each with an occupied flag, a done flag and a
// 16-bit cookie whose low SLOT_BITS bits are the slot index and whose upper
// bits come from the random word given with an allocate request. Requests
// are handled one at a time by a small sequencer around a single slot
// select and cookie compare unit, so the input is not ready while a request
// is in work. Allocate and mark-all-done walk the slots one per cycle:
// allocate stops at the first free slot, or after the last slot when the
// table is full, and mark-all-done always walks every slot. Mark-done,
// release and consume read the cookie memory once through its registered
// read port and then compare; a cookie whose index lies beyond the
// table, or an unknown request type, goes straight to the reply. The
// response sits in an output register, so a new request
// is taken while the previous response is still waiting to be collected.
// Every request gives exactly one response.
module cookie_slot_tracker import cst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  store_cmd_t         cmd;
  logic [SLOTS-1:0]   occ;
  logic [SLOTS-1:0]   done;
  logic [CookieW-1:0] rdata;
  logic               rsp_valid;
  logic               rsp_ready;
  rsp_t               rsp;

  logic               out_valid_q, out_valid_d;
  rsp_t               out_rsp_q;

  // sequencer and shared compare unit
  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .cmd_o       (cmd),
    .occ_i       (occ),
    .done_i      (done),
    .rdata_i     (rdata)
  );

  // slot flags and cookie memory
  cst_slot_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .occ_o   (occ),
    .done_o  (done),
    .rdata_o (rdata)
  );

  // output register: free when empty or being drained this cycle
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // response payload, loaded only when the register takes a new response
  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: rtl/core/cst_slot_store.sv
// cst_slot_store: occupied and done flags per slot plus the cookie memory
// depends on cst_pkg
module cst_slot_store import cst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  store_cmd_t         cmd_i,
  output logic [SLOTS-1:0]   occ_o,
  output logic [SLOTS-1:0]   done_o,
  output logic [CookieW-1:0] rdata_o
);

  logic [SLOTS-1:0]   occ_q, occ_d;
  logic [SLOTS-1:0]   done_q, done_d;
  logic [CookieW-1:0] mem [SLOTS];
  logic [CookieW-1:0] rdata_q;

  always_comb begin
    occ_d  = occ_q;
    done_d = done_q;
    if (cmd_i.set_occ) begin
      occ_d[cmd_i.addr] = 1'b1;
    end else if (cmd_i.clr_occ) begin
      occ_d[cmd_i.addr] = 1'b0;
    end
    if (cmd_i.set_done) begin
      done_d[cmd_i.addr] = 1'b1;
    end else if (cmd_i.clr_done) begin
      done_d[cmd_i.addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= '0;
    end else begin
      occ_q  <= occ_d;
      done_q <= done_d;
    end
  end

  // cookie memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.cookie_we) begin
      mem[cmd_i.addr] <= cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[cmd_i.addr];
    end
  end

  assign occ_o   = occ_q;
  assign done_o  = done_q;
  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cst_ctrl.sv
// cst_ctrl: sequencer with the shared slot index and cookie compare unit
// depends on cst_pkg; drives cst_slot_store
module cst_ctrl import cst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  req_t               req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rsp_t               rsp_o,
  output store_cmd_t         cmd_o,
  input  logic [SLOTS-1:0]   occ_i,
  input  logic [SLOTS-1:0]   done_i,
  input  logic [CookieW-1:0] rdata_i
);

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  rsp_t            rsp_q, rsp_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  logic            req_fire;
  logic [IdxW-1:0] cookie_slot;
  logic [IdxW-1:0] slot;
  logic            slot_occ;
  logic            slot_done;
  logic            cookie_hit;
  logic            scan_last;

  assign req_fire    = req_valid_i && (state_q == ST_IDLE);
  assign cookie_slot = IdxW'(req_q.cookie_in[SLOT_BITS-1:0]);

  // shared unit: slot select and compare
  assign slot       = (state_q == ST_SCAN) ? cnt_q : cookie_slot;
  assign slot_occ   = occ_i[slot];
  assign slot_done  = done_i[slot];
  assign cookie_hit = slot_occ && (rdata_i == req_q.cookie_in);
  assign scan_last  = (cnt_q == IdxW'(SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.req_type)
            REQ_ALLOC, REQ_MARK_ALL: state_d = ST_SCAN;
            REQ_MARK_DONE, REQ_RELEASE, REQ_CONSUME: begin
              state_d = slot_in_range(req_i.cookie_in[SLOT_BITS-1:0]) ? ST_READ : ST_REPLY;
            end
            default: state_d = ST_REPLY;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last || (req_q.req_type == REQ_ALLOC && !slot_occ)) begin
          state_d = ST_REPLY;
        end
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_REPLY;
      ST_REPLY: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs, store commands and datapath registers
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    rsp_valid_o = (state_q == ST_REPLY);
    req_d       = req_q;
    rsp_d       = rsp_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.addr  = slot;
    cmd_o.wdata = {req_q.random_bits[CookieW-1:SLOT_BITS], SLOT_BITS'(cnt_q)};
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          req_d = req_i;
          cnt_d = '0;
          rsp_d.status     = STAT_NO_MATCH;
          rsp_d.cookie_out = '0;
          rsp_d.done_flag  = (req_i.req_type == REQ_CONSUME);
        end
      end
      ST_SCAN: begin
        if (req_q.req_type == REQ_ALLOC) begin
          if (!slot_occ) begin
            cmd_o.cookie_we  = 1'b1;
            cmd_o.set_occ    = 1'b1;
            cmd_o.clr_done   = 1'b1;
            rsp_d.status     = STAT_OK;
            rsp_d.cookie_out = cmd_o.wdata;
          end else if (scan_last) begin
            rsp_d.status = STAT_FULL;
          end
        end else begin
          cmd_o.set_done = slot_occ;
          if (scan_last) begin
            rsp_d.status = STAT_OK;
          end
        end
        cnt_d = cnt_q + 1'b1;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_CHECK: begin
        if (cookie_hit) begin
          rsp_d.status    = STAT_OK;
          rsp_d.done_flag = 1'b0;
          case (req_q.req_type)
            REQ_MARK_DONE: cmd_o.set_done = 1'b1;
            REQ_RELEASE: begin
              cmd_o.clr_occ  = 1'b1;
              cmd_o.clr_done = 1'b1;
            end
            REQ_CONSUME: begin
              rsp_d.done_flag = slot_done;
              cmd_o.clr_occ   = slot_done;
              cmd_o.clr_done  = slot_done;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  a_reply_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPLY && !rsp_ready_i) |=> (state_q == ST_REPLY))
    else $error("reply dropped before hand-off");

  a_read_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_CHECK))
    else $error("cookie compare skipped after read");

  a_write_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cookie_we |-> (state_q == ST_SCAN && req_q.req_type == REQ_ALLOC && !slot_occ))
    else $error("cookie write outside an allocate");

  a_no_set_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.set_occ && cmd_o.clr_occ) && !(cmd_o.set_done && cmd_o.clr_done))
    else $error("slot flag set and cleared together");

endmodule

// File: tb/sv/cookie_slot_tracker_test.sv
// cookie_slot_tracker_test: self-checking bench for the cookie slot tracker
// drives requests through valid/ready, predicts every response and compares
// depends on cst_pkg and cookie_slot_tracker
`timescale 1ns / 1ps

module cookie_slot_tracker_test;
  import cst_pkg::*;

  localparam int unsigned CLK_PERIOD   = 2;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_REQS  = 500;
  // last stretch runs with no idling on either side
  localparam int unsigned QUIET_REQS   = 60;
  // window of back-to-back requests in which the receiver holds off
  localparam int unsigned PRESSURE_AT  = 120;
  localparam int unsigned PRESSURE_END = 180;
  localparam int unsigned HOLD_CYCLES  = 60;
  // cycles with no request or response taken before the run is abandoned
  localparam int unsigned STALL_LIMIT  = 2000;
  // slowest requests walk every slot: mark-all-done, allocate when full
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;

  // request types the block has no handler for
  localparam logic [2:0] REQ_UNDEF_LO  = 3'd5;
  localparam logic [2:0] REQ_UNDEF_MID = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI  = 3'd7;

  localparam logic [CookieW-1:0] IDX_MASK = CookieW'((1 << SLOT_BITS) - 1);

  // one row of the directed table; typed expectation only where fixed is set
  typedef struct packed {
    logic [2:0]         kind;
    logic [CookieW-1:0] cookie;
    logic [CookieW-1:0] rnd;
    logic               fixed;
    logic [1:0]         status;
    logic [CookieW-1:0] cookie_out;
    logic               done_flag;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 25;

  plan_row_t handle_plan [0:PLAN_ROWS-1] = '{
    // empty table: every lookup misses, mark-all-done still succeeds
    '{REQ_CONSUME,   16'h0000, 16'h0000, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b1},
    '{REQ_MARK_DONE, 16'hFFFF, 16'hFFFF, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    '{REQ_RELEASE,   16'h1234, 16'h0000, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    '{REQ_MARK_ALL,  16'h0000, 16'h0000, 1'b1, STAT_OK,       16'h0000, 1'b0},
    // unknown request types are ignored
    '{REQ_UNDEF_LO,  16'h0000, 16'h0000, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    '{REQ_UNDEF_MID, 16'hFFFF, 16'hFFFF, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    '{REQ_UNDEF_HI,  16'h0000, 16'h0000, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    // fill every slot, random word at both extremes
    '{REQ_ALLOC,     16'h0000, 16'hFFFF, 1'b1, STAT_OK,       16'hFFF8, 1'b0},
    '{REQ_ALLOC,     16'hFFFF, 16'h0000, 1'b1, STAT_OK,       16'h0001, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'hA5A5, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'h5A5A, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'h1111, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'h2222, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'h3333, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_ALLOC,     16'h0000, 16'h4444, 1'b0, STAT_OK,       16'h0000, 1'b0},
    // table full
    '{REQ_ALLOC,     16'h0000, 16'hFFFF, 1'b1, STAT_FULL,     16'h0000, 1'b0},
    // done then consume frees, consume of a busy entry keeps it
    '{REQ_MARK_DONE, 16'hFFF8, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_CONSUME,   16'hFFF8, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_CONSUME,   16'h0001, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    // right index, wrong generation bits
    '{REQ_MARK_DONE, 16'h0009, 16'h0000, 1'b1, STAT_NO_MATCH, 16'h0000, 1'b0},
    '{REQ_RELEASE,   16'h0001, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_MARK_ALL,  16'h0000, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    '{REQ_CONSUME,   16'hA5A2, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0},
    // all-zero cookie handed out for slot 0
    '{REQ_ALLOC,     16'h0000, 16'h0000, 1'b1, STAT_OK,       16'h0000, 1'b0},
    '{REQ_CONSUME,   16'h0000, 16'h0000, 1'b0, STAT_OK,       16'h0000, 1'b0}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // shadow copy of the handle table
  bit                 slot_busy   [SLOTS];
  bit                 slot_done   [SLOTS];
  logic [CookieW-1:0] slot_cookie [SLOTS];

  rsp_t pending_rsps [$];

  int unsigned mismatches;
  int unsigned reqs_sent;
  int unsigned rsps_checked;
  int unsigned full_seen;
  int unsigned consumed_done;
  int unsigned misses_seen;
  int unsigned quiet_cycles;
  bit          hold_off_req;
  bit          idling_on;

  cookie_slot_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // apply one request to the shadow table and return the response it earns
  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    int unsigned idx;
    bit          hit;
    o        = '0;
    o.status = STAT_NO_MATCH;
    idx      = int'(r.cookie_in & IDX_MASK);
    // lookups go through the index bits; the whole cookie has to agree
    hit = (idx < SLOTS) && slot_busy[idx] && (slot_cookie[idx] == r.cookie_in);
    case (r.req_type)
      REQ_ALLOC: begin
        o.status = STAT_FULL;
        // lowest free slot wins
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_done[i]   = 1'b0;
            slot_cookie[i] = (r.random_bits & ~IDX_MASK) | (CookieW'(i) & IDX_MASK);
            o.status       = STAT_OK;
            o.cookie_out   = slot_cookie[i];
            break;
          end
        end
      end
      REQ_MARK_DONE: begin
        if (hit) begin
          slot_done[idx] = 1'b1;
          o.status       = STAT_OK;
        end
      end
      REQ_RELEASE: begin
        if (hit) begin
          slot_busy[idx] = 1'b0;
          slot_done[idx] = 1'b0;
          o.status       = STAT_OK;
        end
      end
      REQ_CONSUME: begin
        // a miss reads back as done so the caller stops polling
        o.done_flag = 1'b1;
        if (hit) begin
          o.status    = STAT_OK;
          o.done_flag = slot_done[idx];
          if (slot_done[idx]) begin
            slot_busy[idx] = 1'b0;
            slot_done[idx] = 1'b0;
          end
        end
      end
      REQ_MARK_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) slot_done[i] = 1'b1;
        end
        o.status = STAT_OK;
      end
      default: ;
    endcase
    return o;
  endfunction

  // mostly allocations and requests against live handles, the rest mark-all, stale or junk
  function automatic req_t pick_handle_request();
    req_t               r;
    int unsigned        live [$];
    int unsigned        roll;
    logic [CookieW-1:0] live_cookie;
    r.random_bits = 16'($urandom);
    r.cookie_in   = 16'($urandom);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i]) live.push_back(i);
    end
    live_cookie = r.cookie_in;
    if (live.size() != 0) begin
      live_cookie = slot_cookie[live[$urandom_range(0, live.size() - 1)]];
    end
    roll = $urandom_range(0, 99);
    if (roll < 26) begin
      r.req_type = REQ_ALLOC;
    end else if (roll < 46) begin
      r.req_type  = REQ_MARK_DONE;
      r.cookie_in = live_cookie;
    end else if (roll < 62) begin
      r.req_type  = REQ_CONSUME;
      r.cookie_in = live_cookie;
    end else if (roll < 73) begin
      r.req_type  = REQ_RELEASE;
      r.cookie_in = live_cookie;
    end else if (roll < 79) begin
      r.req_type = REQ_MARK_ALL;
    end else if (roll < 88) begin
      // stale handle: right slot, generation bits disturbed
      r.req_type  = 3'($urandom_range(REQ_MARK_DONE, REQ_CONSUME));
      r.cookie_in = live_cookie ^ (16'($urandom_range(1, 16'hFFFF)) & ~IDX_MASK);
    end else if (roll < 96) begin
      r.req_type = 3'($urandom_range(REQ_MARK_DONE, REQ_CONSUME));
    end else begin
      r.req_type = 3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h, expected %0h (response %0d, t=%0t)",
             what, got, want, rsps_checked, $realtime);
    mismatches++;
  endtask

  // offer one request, wait for the handshake, then log what it should return
  task automatic offer_request(req_t r, bit fixed, rsp_t typed);
    rsp_t        want;
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    want = table_apply(r);
    // typed rows stand on their own; the shadow table still follows them
    if (fixed) want = typed;
    pending_rsps.push_back(want);
    reqs_sent++;
    if (want.status == STAT_FULL) full_seen++;
    if (want.status == STAT_NO_MATCH) misses_seen++;
    if (r.req_type == REQ_CONSUME && want.status == STAT_OK && want.done_flag) begin
      consumed_done++;
    end
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // compare each collected response with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("unexpected response", out_rsp_o, 0);
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", out_rsp_o.status, want.status);
        if (out_rsp_o.cookie_out !== want.cookie_out)
          report_mismatch("cookie_out", out_rsp_o.cookie_out, want.cookie_out);
        if (out_rsp_o.done_flag !== want.done_flag)
          report_mismatch("done_flag", out_rsp_o.done_flag, want.done_flag);
      end
      rsps_checked++;
    end
  end

  // watchdog: cycles in which neither side moves a request or response
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence: reset, directed table, random requests, drain
  initial begin
    req_t        r;
    rsp_t        typed;
    int unsigned k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    hold_off_req = 1'b0;
    idling_on    = 1'b1;
    quiet_cycles = 0;
    mismatches   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i]   = 1'b0;
      slot_done[i]   = 1'b0;
      slot_cookie[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (handle_plan[i]) begin
      r.req_type         = handle_plan[i].kind;
      r.cookie_in        = handle_plan[i].cookie;
      r.random_bits      = handle_plan[i].rnd;
      typed.status       = handle_plan[i].status;
      typed.cookie_out   = handle_plan[i].cookie_out;
      typed.done_flag    = handle_plan[i].done_flag;
      offer_request(r, handle_plan[i].fixed, typed);
    end

    for (k = 0; k < RANDOM_REQS; k++) begin
      // back-to-back window so the hold-off backs requests up into the block
      idling_on = (k < RANDOM_REQS - QUIET_REQS) && !(k >= PRESSURE_AT && k < PRESSURE_END);
      if (k == PRESSURE_AT) hold_off_req = 1'b1;
      offer_request(pick_handle_request(), 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // watchdog bounds this wait
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked, %0d mismatches",
             reqs_sent, rsps_checked, mismatches);
    $display("table full %0d times, %0d done handles consumed, %0d misses or ignored",
             full_seen, consumed_done, misses_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
